// ===== rtl/abss_pkg.sv =====
// abss_pkg: shared types and constants for the adc burst scan sequencer
// used by every module in rtl/; no dependencies of its own
package abss_pkg;

    // number of scanned channels and derived widths
    localparam int NUM_CHANNELS  = 8;
    localparam int CH_IDX_W      = $clog2(NUM_CHANNELS);
    localparam int CH_FIELD_W    = 4;
    localparam int CONV_CH_W     = 3;
    localparam int SAMPLE_W      = 12;
    localparam int TIME_W        = 32;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;

    // channel number of the last channel in a burst
    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);

    // interval after reset in ms
    localparam logic [TIME_W-1:0] INTERVAL_RST = TIME_W'(1000);

    // stream word widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // item kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_POLL   = 2'd0,
        ACT_RESULT = 2'd1,
        ACT_READ   = 2'd2,
        ACT_SINGLE = 2'd3
    } t_action;

    // burst status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NEVER = 2'd0,
        ST_RUN   = 2'd1,
        ST_DONE  = 2'd2
    } t_status;

    // one input word
    typedef struct packed {
        t_action                 action;
        logic [TIME_W-1:0]       now_ms;
        logic [SAMPLE_W-1:0]     sample;
        logic [CH_FIELD_W-1:0]   channel;
    } t_item;

    // one result word
    typedef struct packed {
        logic                    convert_start;
        logic [CONV_CH_W-1:0]    convert_channel;
        logic [SAMPLE_W-1:0]     read_value;
        t_status                 burst_status;
        logic                    single_refused;
    } t_result;

    // handshake between input stage and scan core
    typedef struct packed {
        logic valid;
        logic take;
    } t_stage_ctl;

endpackage

// ===== rtl/abss_in_stage.sv =====
// abss_in_stage: input register for one word of the scan sequencer
// depends on abss_pkg
module abss_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  abss_pkg::t_item     i_item,
    input  logic                i_take,
    output logic                o_valid,
    output abss_pkg::t_item     o_item
);
    import abss_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  s_accept;

    // room when empty or when the held word moves on this cycle
    assign o_s_ready = !r_valid || i_take;
    assign s_accept  = i_s_valid && o_s_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/abss_scan_core.sv =====
// abss_scan_core: burst timing, channel sequencing, sample store and result register
// depends on abss_pkg
module abss_scan_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [abss_pkg::TIME_W-1:0] i_cfg_data,
    input  abss_pkg::t_item             i_item,
    input  logic                        i_item_valid,
    output abss_pkg::t_stage_ctl        o_ctl,
    input  logic                        i_m_ready,
    output logic                        o_m_valid,
    output abss_pkg::t_result           o_res
);
    import abss_pkg::*;

    logic [TIME_W-1:0]   r_interval;
    logic [TIME_W-1:0]   r_start_time, n_start_time;
    logic [CH_IDX_W-1:0] r_cur, n_cur;
    logic                r_active, n_active;
    t_status             r_status, n_status;
    logic [SAMPLE_W-1:0] r_store [NUM_CHANNELS];
    logic                r_out_valid;
    t_result             r_res, n_res;

    logic                advance;
    logic                store_we;
    logic [TIME_W-1:0]   elapsed;
    logic                ch_in_range;
    logic [SAMPLE_W-1:0] store_rd;

    // word moves from input register into result register
    assign advance     = i_item_valid && (!r_out_valid || i_m_ready);
    assign o_ctl.valid = i_item_valid;
    assign o_ctl.take  = advance;

    assign elapsed     = i_item.now_ms - r_start_time;
    assign ch_in_range = {1'b0, i_item.channel} < (CH_FIELD_W + 1)'(NUM_CHANNELS);
    assign store_rd    = ch_in_range ? r_store[i_item.channel[CH_IDX_W-1:0]]
                                     : '0;
    assign store_we    = (i_item.action == ACT_RESULT) && r_active;

    // next state and result for the word in the input register
    always_comb begin
        n_start_time = r_start_time;
        n_cur        = r_cur;
        n_active     = r_active;
        n_status     = r_status;
        n_res.convert_start   = 1'b0;
        n_res.read_value      = '0;
        n_res.single_refused  = 1'b0;
        n_res.convert_channel = '0;
        unique case (i_item.action)
            ACT_POLL: begin
                if (elapsed > r_interval) begin
                    n_status     = ST_RUN;
                    n_active     = 1'b1;
                    n_cur        = '0;
                    n_start_time = r_start_time + r_interval;
                    n_res.convert_start = 1'b1;
                end
            end
            ACT_RESULT: begin
                if (r_active) begin
                    if (r_cur == LAST_CH) begin
                        n_cur    = '0;
                        n_status = ST_DONE;
                        n_active = 1'b0;
                    end else begin
                        n_cur = r_cur + 1'b1;
                        n_res.convert_start = 1'b1;
                    end
                end else begin
                    n_res.read_value = i_item.sample;
                end
            end
            ACT_READ: begin
                n_res.read_value = store_rd;
            end
            ACT_SINGLE: begin
                if (r_active) begin
                    n_res.single_refused = 1'b1;
                end else if (ch_in_range) begin
                    n_res.convert_start = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // channel shown is the requested one for an accepted single request
        if (i_item.action == ACT_SINGLE && !r_active && ch_in_range) begin
            n_res.convert_channel = CONV_CH_W'(i_item.channel);
        end else begin
            n_res.convert_channel = CONV_CH_W'(n_cur);
        end
        n_res.burst_status = n_status;
    end

    // interval register; the user must write it only while idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_valid) begin
            r_interval <= i_cfg_data;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time <= '0;
            r_cur        <= '0;
            r_active     <= 1'b0;
            r_status     <= ST_NEVER;
        end else if (advance) begin
            r_start_time <= n_start_time;
            r_cur        <= n_cur;
            r_active     <= n_active;
            r_status     <= n_status;
        end
    end

    // sample store, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_store[i] <= '0;
            end
        end else if (advance && store_we) begin
            r_store[r_cur] <= i_item.sample;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_res     = r_res;

endmodule

// ===== rtl/adc_burst_scan_sequencer.sv =====
// adc_burst_scan_sequencer: top level, stream ports around input stage and scan core
// depends on abss_pkg, abss_in_stage, abss_scan_core
//
// Usage:
//   slave stream: one word per event (poll time, conversion result, read,
//   single conversion request), kind in i_s_tuser, operands in i_s_tdata.
//   master stream: one result word per input word, in order: convert
//   command, channel, read value, burst status and refusal flag.
//   config channel: i_cfg_valid/i_cfg_data write the burst interval in ms;
//   o_cfg_ready is always high, write only while no word is in flight.
// Path: an accepted word passes the input register, then the result
//   register, before it shows on the master side.
// Throughput: one word per clock while i_m_tready stays high; the scan
//   state is updated between the two registers as each word advances.
// Reset (synchronous, active low): interval 1000 ms, store cleared, no
//   burst running, status never started, both registers empty.
// Stall: while i_m_tready is low the result word holds; one more word
//   waits in the input register, then o_s_tready drops.
module adc_burst_scan_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [1:0] action
    input  logic [abss_pkg::ACTION_W-1:0]      i_s_tuser,
    // [31:0] now_ms, [43:32] sample, [47:44] channel
    input  logic [abss_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] convert_start, [3:1] convert_channel, [15:4] read_value,
    // [17:16] burst_status, [18] single_refused, [23:19] zero
    output logic [abss_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // configuration write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [abss_pkg::TIME_W-1:0]        i_cfg_data
);
    import abss_pkg::*;

    t_item      s_item;
    t_item      q_item;
    logic       q_valid;
    t_stage_ctl ctl;
    t_result    res;

    // unpack the slave word
    assign s_item.action  = t_action'(i_s_tuser);
    assign s_item.now_ms  = i_s_tdata[31:0];
    assign s_item.sample  = i_s_tdata[43:32];
    assign s_item.channel = i_s_tdata[47:44];

    assign o_cfg_ready = 1'b1;

    abss_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_item    (s_item),
        .i_take    (ctl.take),
        .o_valid   (q_valid),
        .o_item    (q_item)
    );

    abss_scan_core u_scan_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_ctl        (ctl),
        .i_m_ready    (i_m_tready),
        .o_m_valid    (o_m_tvalid),
        .o_res        (res)
    );

    // pack the master word
    assign o_m_tdata = {5'b0, res.single_refused, res.burst_status, res.read_value,
                        res.convert_channel, res.convert_start};

`ifndef SYNTHESIS
    // input side blocks only behind a full result register
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && ctl.valid))
        else $error("slave side stalled without a full pipeline");

    // a refusal is only given while a burst runs
    a_refuse_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[18]) |-> (o_m_tdata[17:16] == ST_RUN))
        else $error("single request refused outside a burst");

    // a word with read data never commands a conversion or a refusal
    a_read_no_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[15:4] != '0)) |-> (!o_m_tdata[0] && !o_m_tdata[18]))
        else $error("read data together with a command");
`endif

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for adc_burst_scan_sequencer, stream in/out plus interval writes
// depends on abss_pkg and the rtl top level; predicts every result word and compares in order
module tb;
    import abss_pkg::*;

    // one queued stimulus entry: either an input word or an interval write
    typedef struct {
        logic                   is_cfg;
        logic [TIME_W-1:0]      cfg_value;
        t_item                  item;
    } t_stim;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [ACTION_W-1:0]        i_s_tuser = '0;
    logic [IN_DATA_W-1:0]       i_s_tdata = '0;
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]      o_m_tdata;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [TIME_W-1:0]          i_cfg_data = '0;

    adc_burst_scan_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_stim                      pending_words[$];
    t_result                    expected_results[$];
    int                         mismatches = 0;
    int                         words_taken = 0;
    int                         results_seen = 0;

    // scan state mirrored by the predictor
    logic [SAMPLE_W-1:0]        mdl_store [NUM_CHANNELS];
    logic [CH_IDX_W-1:0]        mdl_ch = '0;
    logic                       mdl_active = 1'b0;
    logic [TIME_W-1:0]          mdl_start = '0;
    t_status                    mdl_status = ST_NEVER;
    logic [TIME_W-1:0]          mdl_interval = INTERVAL_RST;

    // stimulus-side view of burst timing, used only to shape poll times
    logic [TIME_W-1:0]          gen_start = '0;
    logic [TIME_W-1:0]          gen_interval = INTERVAL_RST;
    int                         item_total = 0;

    // apply one word to the mirrored scan state and return the result word
    function automatic t_result scan_step(input t_item it);
        t_result             r;
        logic [TIME_W-1:0]   elapsed;
        logic                ch_given;
        r = '0;
        ch_given = 1'b0;
        case (it.action)
            ACT_POLL: begin
                elapsed = it.now_ms - mdl_start;
                if (elapsed > mdl_interval) begin
                    mdl_status = ST_RUN;
                    mdl_active = 1'b1;
                    mdl_ch = '0;
                    r.convert_start = 1'b1;
                    mdl_start = mdl_start + mdl_interval;
                end
            end
            ACT_RESULT: begin
                if (mdl_active) begin
                    mdl_store[mdl_ch] = it.sample;
                    if (mdl_ch == LAST_CH) begin
                        mdl_ch = '0;
                        mdl_status = ST_DONE;
                        mdl_active = 1'b0;
                    end else begin
                        mdl_ch = mdl_ch + 1'b1;
                        r.convert_start = 1'b1;
                    end
                end else begin
                    r.read_value = it.sample;
                end
            end
            ACT_READ: begin
                if (it.channel < NUM_CHANNELS)
                    r.read_value = mdl_store[it.channel[CH_IDX_W-1:0]];
            end
            default: begin
                if (mdl_active) begin
                    r.single_refused = 1'b1;
                end else if (it.channel < NUM_CHANNELS) begin
                    r.convert_start = 1'b1;
                    r.convert_channel = it.channel[CONV_CH_W-1:0];
                    ch_given = 1'b1;
                end
            end
        endcase
        if (!ch_given)
            r.convert_channel = mdl_ch;
        r.burst_status = mdl_status;
        return r;
    endfunction

    // stimulus builders
    task automatic add_item(input t_action act, input logic [TIME_W-1:0] now,
                            input logic [SAMPLE_W-1:0] smp, input logic [CH_FIELD_W-1:0] ch);
        t_stim               s;
        logic [TIME_W-1:0]   elapsed;
        s.is_cfg = 1'b0;
        s.cfg_value = '0;
        s.item.action = act;
        s.item.now_ms = now;
        s.item.sample = smp;
        s.item.channel = ch;
        pending_words.push_back(s);
        item_total++;
        elapsed = now - gen_start;
        if (act == ACT_POLL && elapsed > gen_interval)
            gen_start = gen_start + gen_interval;
    endtask

    task automatic add_cfg(input logic [TIME_W-1:0] value);
        t_stim s;
        s.is_cfg = 1'b1;
        s.cfg_value = value;
        s.item = '0;
        pending_words.push_back(s);
        gen_interval = value;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CH_FIELD_W-1:0] rand_channel();
        if ($urandom_range(0, 3) == 0)
            return CH_FIELD_W'($urandom_range(NUM_CHANNELS, 15));
        return CH_FIELD_W'($urandom_range(0, NUM_CHANNELS - 1));
    endfunction

    // a poll that fires, then results for every channel or a cut-short run of them, with side traffic in between
    task automatic add_burst();
        int cut;
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NUM_CHANNELS - 1) : NUM_CHANNELS;
        add_item(ACT_POLL, gen_start + gen_interval + 1 + $urandom_range(0, 3),
                 rand_sample(), rand_channel());
        for (int k = 0; k < cut; k++) begin
            case ($urandom_range(0, 11))
                0: add_item(ACT_READ, $urandom, rand_sample(), rand_channel());
                1: add_item(ACT_SINGLE, $urandom, rand_sample(), rand_channel());
                2: add_item(ACT_POLL, gen_start + $urandom_range(0, gen_interval),
                            rand_sample(), rand_channel());
                3: begin
                    // interval elapses again mid-burst: fresh start on channel 0
                    if ($urandom_range(0, 3) == 0)
                        add_item(ACT_POLL, gen_start + gen_interval + 1, rand_sample(),
                                 rand_channel());
                end
                default: ;
            endcase
            add_item(ACT_RESULT, $urandom, rand_sample(), rand_channel());
        end
        if ($urandom_range(0, 1) == 0)
            add_item(ACT_READ, $urandom, rand_sample(), rand_channel());
    endtask

    task automatic add_random_phase(input int n_items);
        int stop_at;
        stop_at = item_total + n_items;
        while (item_total < stop_at) begin
            if ($urandom_range(0, 9) < 7)
                add_burst();
            else
                add_item(t_action'($urandom_range(0, 3)), $urandom, rand_sample(),
                         CH_FIELD_W'($urandom));
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // check one field of a result word
    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
            mismatches++;
        end
    endtask

    // driver: offers queued words, holds interval writes until the pipe is empty
    t_item  offered_word;
    int     gap_left = 0;
    int     quiet_cycles = 0;

    always @(posedge i_clk) begin : drive
        t_stim  nxt;
        int     g;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_left <= 0;
            quiet_cycles = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(scan_step(offered_word));
                words_taken++;
            end
            if (i_cfg_valid && o_cfg_ready)
                mdl_interval = i_cfg_data;
            if (expected_results.size() == 0 && !i_s_tvalid)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            if (!((i_s_tvalid && !o_s_tready) || (i_cfg_valid && !o_cfg_ready))) begin
                // no-gap stretch for a quarter of the run
                if (i_s_tvalid && o_s_tready)
                    g = (words_taken % 256 >= 192) ? 0 : pick_gap();
                else
                    g = gap_left;
                if (g > 0) begin
                    gap_left <= g - 1;
                    i_s_tvalid <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    gap_left <= 0;
                    i_s_tvalid <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end else if (pending_words[0].is_cfg) begin
                    gap_left <= 0;
                    i_s_tvalid <= 1'b0;
                    // write the interval only once every word has drained
                    if (quiet_cycles >= 4 && !i_cfg_valid) begin
                        nxt = pending_words.pop_front();
                        i_cfg_valid <= 1'b1;
                        i_cfg_data <= nxt.cfg_value;
                    end else begin
                        i_cfg_valid <= 1'b0;
                    end
                end else begin
                    gap_left <= 0;
                    nxt = pending_words.pop_front();
                    offered_word = nxt.item;
                    i_s_tvalid <= 1'b1;
                    i_cfg_valid <= 1'b0;
                    i_s_tuser <= nxt.item.action;
                    i_s_tdata <= {nxt.item.channel, nxt.item.sample, nxt.item.now_ms};
                end
            end
        end
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    int     stall_left = 0;
    int     hold_left = 0;
    logic   hold_done = 1'b0;

    always @(posedge i_clk) begin : receive
        int r;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 500) begin
            // long hold-off so the input side backs up
            hold_done <= 1'b1;
            hold_left <= 60;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (results_seen % 256 < 64) begin
            i_m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_m_tready <= 1'b1;
            end else if (r < 96) begin
                i_m_tready <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_m_tready <= 1'b0;
                stall_left <= $urandom_range(10, 30);
            end
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %0h",
                         $time, o_m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("convert_start", want.convert_start, o_m_tdata[0]);
                check_field("convert_channel", want.convert_channel, o_m_tdata[3:1]);
                check_field("read_value", want.read_value, o_m_tdata[15:4]);
                check_field("burst_status", want.burst_status, o_m_tdata[17:16]);
                check_field("single_refused", want.single_refused, o_m_tdata[18]);
                check_field("padding", 32'd0, o_m_tdata[OUT_DATA_W-1:19]);
            end
        end
    end

    // timeout
    initial begin
        #(12 * 800000);
        $display("tb failed");
        $finish;
    end

    // stimulus plan, reset and end of run
    initial begin
        for (int i = 0; i < NUM_CHANNELS; i++)
            mdl_store[i] = '0;

        // directed: idle reads, singles, pass-through, interval edge, full burst, wrap
        add_item(ACT_READ, 32'd0, 12'd0, 4'd0);
        add_item(ACT_SINGLE, 32'd0, 12'd0, 4'd3);
        add_item(ACT_SINGLE, 32'hFFFF_FFFF, 12'hFFF, 4'd15);
        add_item(ACT_RESULT, 32'd0, 12'hABC, 4'd0);
        add_item(ACT_POLL, 32'd1000, 12'd0, 4'd0);
        add_item(ACT_POLL, 32'd1001, 12'd0, 4'd0);
        add_item(ACT_SINGLE, 32'd0, 12'd0, 4'd2);
        add_item(ACT_POLL, 32'd1500, 12'd0, 4'd0);
        add_item(ACT_READ, 32'd0, 12'd0, 4'd9);
        add_item(ACT_RESULT, 32'd0, 12'hFFF, 4'd0);
        add_item(ACT_RESULT, 32'd0, 12'h000, 4'd0);
        add_item(ACT_RESULT, 32'd0, 12'h555, 4'd0);
        add_item(ACT_RESULT, 32'd0, 12'hAAA, 4'd0);
        add_item(ACT_RESULT, 32'd0, 12'h001, 4'd0);
        add_item(ACT_RESULT, 32'd0, 12'h123, 4'd0);
        add_item(ACT_RESULT, 32'd0, 12'h7FF, 4'd0);
        add_item(ACT_RESULT, 32'd0, 12'h800, 4'd0);
        add_item(ACT_READ, 32'd0, 12'd0, 4'd0);
        add_item(ACT_READ, 32'd0, 12'd0, 4'd7);
        add_item(ACT_READ, 32'd0, 12'd0, 4'd8);
        add_item(ACT_READ, 32'd0, 12'd0, 4'd15);
        add_item(ACT_POLL, 32'hFFFF_FFFF, 12'd0, 4'd0);
        add_item(ACT_POLL, 32'd5, 12'd0, 4'd0);
        add_item(ACT_RESULT, 32'd0, 12'hFFF, 4'd0);
        add_item(ACT_SINGLE, 32'd0, 12'd0, 4'd0);

        // random phases over several intervals, extremes included
        add_random_phase(190);
        add_cfg(32'd0);
        add_random_phase(190);
        add_cfg(32'hFFFF_FFFF);
        add_random_phase(190);
        add_cfg(32'd3);
        add_random_phase(190);
        add_cfg(TIME_W'($urandom_range(50, 100000)));
        add_random_phase(190);
        add_cfg(32'h8000_0000);
        add_random_phase(190);
        add_cfg(32'd1000);
        add_random_phase(190);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_words.size() != 0 || i_s_tvalid || i_cfg_valid ||
               expected_results.size() != 0);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/abss_pkg.sv
rtl/abss_in_stage.sv
rtl/abss_scan_core.sv
rtl/adc_burst_scan_sequencer.sv
verif/tb.sv
